// ===== design/pcsd_pkg.sv =====
package pcsd_pkg;

    localparam int COORD_W    = 32;
    localparam int AXIS_W     = 18;
    localparam int LEN_W      = 31;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int N_W     = COORD_W + 1;          // point minus center
    localparam int PROD_W  = AXIS_W + N_W;         // axis * offset
    localparam int DOT_W   = PROD_W + 2;           // sum of three products
    localparam int NN_W    = 2 * N_W;              // sum of three squares
    localparam int Y_W     = 35;                   // rounded |dot| in Q.16
    localparam int YY_W    = 2 * Y_W;
    localparam int SQ_BITS = (NN_W + 2) / 2;       // root bits, one per cell
    localparam int RAD_W   = 2 * SQ_BITS;          // padded radicand
    localparam int REM_W   = SQ_BITS + 4;          // partial remainder
    localparam int D_W     = SQ_BITS + 1;
    localparam int E_W     = 80;                   // sum of squares, room for rounding
    localparam int SQD_W   = 63;
    localparam int RND_W   = E_W - 16;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_CENTER_X    = 3'd0;
    localparam t_cfg_idx CFG_CENTER_Y    = 3'd1;
    localparam t_cfg_idx CFG_CENTER_Z    = 3'd2;
    localparam t_cfg_idx CFG_AXIS_X      = 3'd3;
    localparam t_cfg_idx CFG_AXIS_Y      = 3'd4;
    localparam t_cfg_idx CFG_AXIS_Z      = 3'd5;
    localparam t_cfg_idx CFG_HALF_LENGTH = 3'd6;
    localparam t_cfg_idx CFG_RADIUS      = 3'd7;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } t_in_item;

    typedef struct packed {
        logic [SQD_W-1:0] sq_distance;
        logic             saturated;
    } t_out_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic signed [AXIS_W-1:0]  axis_x;
        logic signed [AXIS_W-1:0]  axis_y;
        logic signed [AXIS_W-1:0]  axis_z;
        logic [LEN_W-1:0]          half_length;
        logic [LEN_W-1:0]          radius;
    } t_cfg;

    typedef struct packed {
        logic [Y_W-1:0] yc;      // distance beyond the cap, zero inside the slab
        logic           use_d;   // add the radial term
    } t_side;

    typedef struct packed {
        logic               valid;
        logic [RAD_W-1:0]   rad;
        logic [REM_W-1:0]   rem;
        logic [SQ_BITS-1:0] root;
        t_side              side;
    } t_sq_stage;

endpackage

// ===== design/pcsd_front.sv =====
module pcsd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  pcsd_pkg::t_in_item i_item,
    input  pcsd_pkg::t_cfg     i_cfg,
    output pcsd_pkg::t_sq_stage o_stage
);

    logic [4:0] r_v;

    logic signed [pcsd_pkg::N_W-1:0]    r_n    [3];
    logic signed [pcsd_pkg::N_W-1:0]    n_n    [3];
    logic signed [pcsd_pkg::PROD_W-1:0] r_prod [3];
    logic signed [pcsd_pkg::PROD_W-1:0] n_prod [3];
    logic signed [pcsd_pkg::NN_W-1:0]   r_sq   [3];
    logic signed [pcsd_pkg::NN_W-1:0]   n_sq   [3];

    logic signed [pcsd_pkg::DOT_W-1:0] r_dot, n_dot;
    logic [pcsd_pkg::NN_W-1:0]         r_nn3, n_nn3;
    logic [pcsd_pkg::Y_W-1:0]          r_y4, n_y4;
    logic [pcsd_pkg::NN_W-1:0]         r_nn4;
    logic [pcsd_pkg::Y_W-1:0]          r_y5;
    logic [pcsd_pkg::YY_W-1:0]         r_yy5, n_yy5;
    logic [pcsd_pkg::NN_W-1:0]         r_nn5;
    pcsd_pkg::t_sq_stage               r_out, n_out;

    logic [pcsd_pkg::DOT_W-1:0]  dot_mag;
    logic [pcsd_pkg::DOT_W-1:0]  dot_rnd;
    logic [pcsd_pkg::NN_W-1:0]   xx;
    logic [2*pcsd_pkg::LEN_W-1:0] r2;
    logic                        in_slab;

    always_comb begin
        n_n[0] = pcsd_pkg::N_W'(i_item.point_x) - pcsd_pkg::N_W'(i_cfg.center_x);
        n_n[1] = pcsd_pkg::N_W'(i_item.point_y) - pcsd_pkg::N_W'(i_cfg.center_y);
        n_n[2] = pcsd_pkg::N_W'(i_item.point_z) - pcsd_pkg::N_W'(i_cfg.center_z);
        n_prod[0] = i_cfg.axis_x * r_n[0];
        n_prod[1] = i_cfg.axis_y * r_n[1];
        n_prod[2] = i_cfg.axis_z * r_n[2];
        for (int k = 0; k < 3; k++) begin
            n_sq[k] = r_n[k] * r_n[k];
        end
        n_dot = pcsd_pkg::DOT_W'(r_prod[0]) + pcsd_pkg::DOT_W'(r_prod[1])
              + pcsd_pkg::DOT_W'(r_prod[2]);
        n_nn3 = r_sq[0] + r_sq[1] + r_sq[2];

        dot_mag = r_dot[pcsd_pkg::DOT_W-1] ? -r_dot : r_dot;
        dot_rnd = dot_mag + pcsd_pkg::DOT_W'(32768);
        n_y4    = dot_rnd[16 +: pcsd_pkg::Y_W];

        n_yy5 = r_y4 * r_y4;

        // clamp when the axis is not unit length
        xx = (pcsd_pkg::YY_W'(r_nn5) > r_yy5) ? r_nn5 - pcsd_pkg::NN_W'(r_yy5) : '0;
        r2 = i_cfg.radius * i_cfg.radius;
        in_slab = r_y5 < pcsd_pkg::Y_W'(i_cfg.half_length);

        n_out.valid      = r_v[4];
        n_out.rad        = pcsd_pkg::RAD_W'(xx);
        n_out.rem        = '0;
        n_out.root       = '0;
        n_out.side.yc    = in_slab ? '0 : r_y5 - pcsd_pkg::Y_W'(i_cfg.half_length);
        n_out.side.use_d = in_slab ? (xx > pcsd_pkg::NN_W'(r2))
                                   : (xx >= pcsd_pkg::NN_W'(r2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_out.valid <= 1'b0;
        end else if (i_en) begin
            r_v   <= {r_v[3:0], i_valid};
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n   <= n_n;
            r_prod <= n_prod;
            r_sq  <= n_sq;
            r_dot <= n_dot;
            r_nn3 <= n_nn3;
            r_y4  <= n_y4;
            r_nn4 <= r_nn3;
            r_y5  <= r_y4;
            r_yy5 <= n_yy5;
            r_nn5 <= r_nn4;
        end
    end

    assign o_stage = r_out;

endmodule

// ===== design/pcsd_sqrt_cell.sv =====
module pcsd_sqrt_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  pcsd_pkg::t_sq_stage i_stage,
    output pcsd_pkg::t_sq_stage o_stage
);

    pcsd_pkg::t_sq_stage r_stage, n_stage;

    logic [pcsd_pkg::REM_W-1:0] rem_sh;
    logic [pcsd_pkg::REM_W-1:0] trial;
    logic                       take;

    always_comb begin
        rem_sh = {i_stage.rem[pcsd_pkg::REM_W-3:0],
                  i_stage.rad[pcsd_pkg::RAD_W-1 -: 2]};
        trial  = pcsd_pkg::REM_W'({i_stage.root, 2'b01});
        take   = rem_sh >= trial;

        n_stage       = i_stage;
        n_stage.rad   = {i_stage.rad[pcsd_pkg::RAD_W-3:0], 2'b00};
        n_stage.rem   = take ? rem_sh - trial : rem_sh;
        n_stage.root  = {i_stage.root[pcsd_pkg::SQ_BITS-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

// ===== design/pcsd_back.sv =====
module pcsd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  pcsd_pkg::t_sq_stage i_stage,
    input  logic [pcsd_pkg::LEN_W-1:0] i_radius,
    output logic                o_valid,
    output pcsd_pkg::t_out_item o_item
);

    logic [2:0] r_v;

    logic [pcsd_pkg::D_W-1:0]  r_d, n_d;
    logic [pcsd_pkg::Y_W-1:0]  r_yc1;
    logic                      r_use1, r_use2;
    logic [2*pcsd_pkg::D_W-1:0] r_dd, n_dd;
    logic [pcsd_pkg::YY_W-1:0] r_ycc, n_ycc;
    pcsd_pkg::t_out_item       r_out, n_out;

    logic                       round_up;
    logic [pcsd_pkg::D_W-1:0]   x;
    logic [pcsd_pkg::E_W-1:0]   e;
    logic [pcsd_pkg::E_W-1:0]   e_rnd;
    logic [pcsd_pkg::RND_W-1:0] rnd;

    always_comb begin
        // round the floor root up when the remainder exceeds it
        round_up = i_stage.rem > pcsd_pkg::REM_W'(i_stage.root);
        x        = pcsd_pkg::D_W'(i_stage.root) + pcsd_pkg::D_W'(round_up);
        n_d      = (x > pcsd_pkg::D_W'(i_radius)) ? x - pcsd_pkg::D_W'(i_radius) : '0;

        n_dd  = r_d * r_d;
        n_ycc = r_yc1 * r_yc1;

        e     = (r_use2 ? pcsd_pkg::E_W'(r_dd) : '0) + pcsd_pkg::E_W'(r_ycc);
        e_rnd = e + pcsd_pkg::E_W'(32768);
        rnd   = e_rnd[pcsd_pkg::E_W-1:16];
        n_out.saturated   = |rnd[pcsd_pkg::RND_W-1:pcsd_pkg::SQD_W];
        n_out.sq_distance = n_out.saturated ? '1 : rnd[pcsd_pkg::SQD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_stage.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d    <= n_d;
            r_yc1  <= i_stage.side.yc;
            r_use1 <= i_stage.side.use_d;
            r_dd   <= n_dd;
            r_ycc  <= n_ycc;
            r_use2 <= r_use1;
            r_out  <= n_out;
        end
    end

    assign o_valid = r_v[2];
    assign o_item  = r_out;

endmodule

// ===== design/point_cylinder_sq_distance_unit.sv =====
// Channel   Direction  Handshake                    Payload
// in        request    i_in_valid / o_in_stall      i_in_data  (pcsd_pkg::t_in_item)
// out       result     o_out_valid / i_out_stall    o_out_data (pcsd_pkg::t_out_item)
// cfg       write      i_cfg_we                     i_cfg_index, i_cfg_data
//
// One request per cycle unless stalled. There are 6 front stages, one square-root
// cell per root bit (34), and 3 back stages ending in the output register.
// The square-root row sets the latency; throughput is one per cycle unless stalled.
// Synchronous active-low reset clears all valid bits and loads default registers.
// A stalled result freezes the whole pipeline, and o_in_stall follows it.
module point_cylinder_sq_distance_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  pcsd_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output pcsd_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_we,
    input  pcsd_pkg::t_cfg_idx                  i_cfg_index,
    input  logic [pcsd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    pcsd_pkg::t_cfg r_cfg;
    logic           en;

    pcsd_pkg::t_sq_stage w_chain [0:pcsd_pkg::SQ_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x    <= '0;
            r_cfg.center_y    <= '0;
            r_cfg.center_z    <= '0;
            r_cfg.axis_x      <= '0;
            r_cfg.axis_y      <= '0;
            r_cfg.axis_z      <= pcsd_pkg::AXIS_W'(65536);
            r_cfg.half_length <= pcsd_pkg::LEN_W'(65536);
            r_cfg.radius      <= pcsd_pkg::LEN_W'(65536);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pcsd_pkg::CFG_CENTER_X:    r_cfg.center_x    <= i_cfg_data;
                pcsd_pkg::CFG_CENTER_Y:    r_cfg.center_y    <= i_cfg_data;
                pcsd_pkg::CFG_CENTER_Z:    r_cfg.center_z    <= i_cfg_data;
                pcsd_pkg::CFG_AXIS_X:      r_cfg.axis_x      <= i_cfg_data[pcsd_pkg::AXIS_W-1:0];
                pcsd_pkg::CFG_AXIS_Y:      r_cfg.axis_y      <= i_cfg_data[pcsd_pkg::AXIS_W-1:0];
                pcsd_pkg::CFG_AXIS_Z:      r_cfg.axis_z      <= i_cfg_data[pcsd_pkg::AXIS_W-1:0];
                pcsd_pkg::CFG_HALF_LENGTH: r_cfg.half_length <= i_cfg_data[pcsd_pkg::LEN_W-1:0];
                pcsd_pkg::CFG_RADIUS:      r_cfg.radius      <= i_cfg_data[pcsd_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // advance everything unless a finished result is held
    assign en         = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;

    pcsd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_item  (i_in_data),
        .i_cfg   (r_cfg),
        .o_stage (w_chain[0])
    );

    for (genvar g = 0; g < pcsd_pkg::SQ_BITS; g++) begin : g_cell
        pcsd_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_stage (w_chain[g]),
            .o_stage (w_chain[g+1])
        );
    end

    pcsd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_stage  (w_chain[pcsd_pkg::SQ_BITS]),
        .i_radius (r_cfg.radius),
        .o_valid  (o_out_valid),
        .o_item   (o_out_data)
    );

    a_stall_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    a_sat_is_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.saturated) |-> (&o_out_data.sq_distance))
        else $error("saturated result not at maximum");

    a_root_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_chain[pcsd_pkg::SQ_BITS].valid |->
            (w_chain[pcsd_pkg::SQ_BITS].rem <=
             pcsd_pkg::REM_W'({w_chain[pcsd_pkg::SQ_BITS].root, 1'b0})))
        else $error("square root remainder out of range");

    a_empty_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule
